FILE: rtl/grt_pkg.sv
// Shared constants and helper functions for the gamepad report translator.
package grt_pkg;

  localparam int unsigned NumSticks = 4;
  localparam logic [7:0]  ReportIdPad = 8'h01;
  localparam logic [7:0]  StickDeadband = 8'd2;

  // Stick order: left X, left Y, right X, right Y.
  localparam int unsigned StickLx = 0;
  localparam int unsigned StickLy = 1;
  localparam int unsigned StickRx = 2;
  localparam int unsigned StickRy = 3;

  // Hat encodings (low nibble of the hat/face byte); 8..15 mean centered.
  localparam logic [3:0] HatN  = 4'd0;
  localparam logic [3:0] HatNE = 4'd1;
  localparam logic [3:0] HatE  = 4'd2;
  localparam logic [3:0] HatSE = 4'd3;
  localparam logic [3:0] HatS  = 4'd4;
  localparam logic [3:0] HatSW = 4'd5;
  localparam logic [3:0] HatW  = 4'd6;
  localparam logic [3:0] HatNW = 4'd7;

  // Direction bits in the pad button word: up, down, left, right.
  localparam logic [3:0] DirUp    = 4'b0001;
  localparam logic [3:0] DirDown  = 4'b0010;
  localparam logic [3:0] DirLeft  = 4'b0100;
  localparam logic [3:0] DirRight = 4'b1000;
  localparam logic [3:0] DirNone  = 4'b0000;

  function automatic logic [3:0] hat_dirs(input logic [3:0] hat);
    logic [3:0] d;
    unique case (hat)
      HatN:    d = DirUp;
      HatNE:   d = DirUp | DirRight;
      HatE:    d = DirRight;
      HatSE:   d = DirDown | DirRight;
      HatS:    d = DirDown;
      HatSW:   d = DirDown | DirLeft;
      HatW:    d = DirLeft;
      HatNW:   d = DirUp | DirLeft;
      default: d = DirNone;
    endcase
    return d;
  endfunction

  // Remap the raw hat/face, shoulder and system bits to the pad button word.
  function automatic logic [15:0] map_buttons(input logic [7:0] hat_face,
                                              input logic [7:0] shoulder,
                                              input logic [1:0] sys_bits);
    logic [15:0] b;
    b        = 16'h0000;
    b[3:0]   = hat_dirs(hat_face[3:0]);
    b[4]     = shoulder[5];  // option -> start
    b[5]     = shoulder[4];  // share  -> back
    b[6]     = shoulder[6];
    b[7]     = shoulder[7];
    b[8]     = shoulder[0];
    b[9]     = shoulder[1];
    b[10]    = sys_bits[0];
    b[11]    = sys_bits[1];
    b[12]    = hat_face[5];  // cross
    b[13]    = hat_face[6];  // circle
    b[14]    = hat_face[4];  // square
    b[15]    = hat_face[7];  // triangle
    return b;
  endfunction

  function automatic logic moved(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > StickDeadband;
  endfunction

  // s = (raw * 65535) >> 8, then offset to signed; Y axes are inverted.
  function automatic logic [15:0] scale_axis(input logic [7:0] raw,
                                             input logic       invert);
    logic [23:0] prod;
    logic [15:0] s;
    prod = {raw, 16'h0000} - {16'h0000, raw};
    s    = prod[23:8];
    return invert ? (~s ^ 16'h8000) : (s ^ 16'h8000);
  endfunction

endpackage

FILE: rtl/gamepad_report_translator_core.sv
// Gamepad report translator: change detect, button remap, stick scaling.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in      | in  | in_valid_i/in_stall_o  | report_id_i .. host_rumble_right_i
//  out     | out | out_valid_o/out_stall_i| pad_changed_o .. motor_right_drive_o
//
// One transaction per clock sustained while out_stall_i stays low. A report goes
// input register -> result register: it is accepted into the input register and
// loads the result register once that register is free. One layer of compare/
// remap/scale logic sits between the two registers.
// Reports with an id other than 1 are dropped in the input stage with no result.
// Reset (rst_ni low, async) empties both stages and zeroes previous/held state.
// A stalled result holds; the input stage keeps accepting while it can drain.
module gamepad_report_translator_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  report_id_i,
  input  logic [7:0]  left_x_i,
  input  logic [7:0]  left_y_i,
  input  logic [7:0]  right_x_i,
  input  logic [7:0]  right_y_i,
  input  logic [7:0]  hat_face_byte_i,
  input  logic [7:0]  shoulder_byte_i,
  input  logic [7:0]  system_byte_i,
  input  logic [7:0]  left_trigger_in_i,
  input  logic [7:0]  right_trigger_in_i,
  input  logic [7:0]  host_rumble_left_i,
  input  logic [7:0]  host_rumble_right_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pad_changed_o,
  output logic [15:0] pad_buttons_o,
  output logic [7:0]  left_trigger_out_o,
  output logic [7:0]  right_trigger_out_o,
  output logic signed [15:0] stick_left_x_o,
  output logic signed [15:0] stick_left_y_o,
  output logic signed [15:0] stick_right_x_o,
  output logic signed [15:0] stick_right_y_o,
  output logic [7:0]  motor_left_drive_o,
  output logic [7:0]  motor_right_drive_o
);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_id_q;
  logic [7:0] s1_stick_q [grt_pkg::NumSticks];
  logic [7:0] s1_hat_face_q, s1_shoulder_q;
  logic [1:0] s1_sys_q;
  logic [7:0] s1_trig_l_q, s1_trig_r_q;
  logic [7:0] s1_rumble_l_q, s1_rumble_r_q;

  logic in_accept;
  logic s1_is_pad;    // input stage holds a report with the pad id
  logic out_free;     // result register can take a new transaction this edge
  logic s1_advance;   // input stage empties this edge
  logic state_upd;    // pad report retires into the result register

  assign s1_is_pad  = (s1_id_q == grt_pkg::ReportIdPad);
  assign out_free   = !out_valid_o || !out_stall_i;
  // Foreign ids just drain; pad reports need room downstream.
  assign s1_advance = s1_valid_q && (!s1_is_pad || out_free);
  assign state_upd  = s1_valid_q && s1_is_pad && out_free;
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_id_q                         <= report_id_i;
      s1_stick_q[grt_pkg::StickLx]    <= left_x_i;
      s1_stick_q[grt_pkg::StickLy]    <= left_y_i;
      s1_stick_q[grt_pkg::StickRx]    <= right_x_i;
      s1_stick_q[grt_pkg::StickRy]    <= right_y_i;
      s1_hat_face_q                   <= hat_face_byte_i;
      s1_shoulder_q                   <= shoulder_byte_i;
      s1_sys_q                        <= system_byte_i[1:0];  // counter dropped
      s1_trig_l_q                     <= left_trigger_in_i;
      s1_trig_r_q                     <= right_trigger_in_i;
      s1_rumble_l_q                   <= host_rumble_left_i;
      s1_rumble_r_q                   <= host_rumble_right_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Previous-report and held pad state
  // ---------------------------------------------------------------------------
  logic [7:0]  prev_stick_q [grt_pkg::NumSticks];
  logic [7:0]  prev_hat_face_q, prev_shoulder_q;
  logic [1:0]  prev_sys_q;
  logic [7:0]  prev_trig_l_q, prev_trig_r_q;

  logic [15:0] held_buttons_q, held_buttons_d;
  logic [7:0]  held_trig_l_q, held_trig_l_d;
  logic [7:0]  held_trig_r_q, held_trig_r_d;
  logic [15:0] held_stick_q [grt_pkg::NumSticks];
  logic [15:0] held_stick_d [grt_pkg::NumSticks];

  logic [grt_pkg::NumSticks-1:0] stick_moved;
  logic changed;

  always_comb begin
    for (int i = 0; i < grt_pkg::NumSticks; i++) begin
      stick_moved[i] = grt_pkg::moved(prev_stick_q[i], s1_stick_q[i]);
    end
  end

  // Button bytes and triggers compare exactly; sticks use a +/-2 deadband.
  assign changed = (|stick_moved)
                || (prev_hat_face_q != s1_hat_face_q)
                || (prev_shoulder_q != s1_shoulder_q)
                || (prev_sys_q      != s1_sys_q)
                || (prev_trig_l_q   != s1_trig_l_q)
                || (prev_trig_r_q   != s1_trig_r_q);

  always_comb begin
    held_buttons_d = held_buttons_q;
    held_trig_l_d  = held_trig_l_q;
    held_trig_r_d  = held_trig_r_q;
    for (int i = 0; i < grt_pkg::NumSticks; i++) begin
      held_stick_d[i] = held_stick_q[i];
    end
    if (changed) begin
      held_buttons_d = grt_pkg::map_buttons(s1_hat_face_q, s1_shoulder_q, s1_sys_q);
      held_trig_l_d  = s1_trig_l_q;
      held_trig_r_d  = s1_trig_r_q;
      // Y axes (odd index) are inverted so up is positive.
      held_stick_d[grt_pkg::StickLx] =
          grt_pkg::scale_axis(s1_stick_q[grt_pkg::StickLx], 1'b0);
      held_stick_d[grt_pkg::StickLy] =
          grt_pkg::scale_axis(s1_stick_q[grt_pkg::StickLy], 1'b1);
      held_stick_d[grt_pkg::StickRx] =
          grt_pkg::scale_axis(s1_stick_q[grt_pkg::StickRx], 1'b0);
      held_stick_d[grt_pkg::StickRy] =
          grt_pkg::scale_axis(s1_stick_q[grt_pkg::StickRy], 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < grt_pkg::NumSticks; i++) begin
        prev_stick_q[i] <= 8'h00;
        held_stick_q[i] <= 16'h0000;
      end
      prev_hat_face_q <= 8'h00;
      prev_shoulder_q <= 8'h00;
      prev_sys_q      <= 2'b00;
      prev_trig_l_q   <= 8'h00;
      prev_trig_r_q   <= 8'h00;
      held_buttons_q  <= 16'h0000;
      held_trig_l_q   <= 8'h00;
      held_trig_r_q   <= 8'h00;
    end else if (state_upd) begin
      for (int i = 0; i < grt_pkg::NumSticks; i++) begin
        prev_stick_q[i] <= s1_stick_q[i];
        held_stick_q[i] <= held_stick_d[i];
      end
      prev_hat_face_q <= s1_hat_face_q;
      prev_shoulder_q <= s1_shoulder_q;
      prev_sys_q      <= s1_sys_q;
      prev_trig_l_q   <= s1_trig_l_q;
      prev_trig_r_q   <= s1_trig_r_q;
      held_buttons_q  <= held_buttons_d;
      held_trig_l_q   <= held_trig_l_d;
      held_trig_r_q   <= held_trig_r_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic       out_valid_q, out_valid_d;
  logic       use_host;
  logic [7:0] motor_l_d, motor_r_d;

  // Host rumble wins when either byte is nonzero; else triggers drive motors.
  assign use_host  = (s1_rumble_l_q != 8'h00) || (s1_rumble_r_q != 8'h00);
  assign motor_l_d = use_host ? s1_rumble_l_q : s1_trig_l_q;
  assign motor_r_d = use_host ? s1_rumble_r_q : s1_trig_r_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_upd) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_upd) begin
      pad_changed_o       <= changed;
      pad_buttons_o       <= held_buttons_d;
      left_trigger_out_o  <= held_trig_l_d;
      right_trigger_out_o <= held_trig_r_d;
      stick_left_x_o      <= held_stick_d[grt_pkg::StickLx];
      stick_left_y_o      <= held_stick_d[grt_pkg::StickLy];
      stick_right_x_o     <= held_stick_d[grt_pkg::StickRx];
      stick_right_y_o     <= held_stick_d[grt_pkg::StickRy];
      motor_left_drive_o  <= motor_l_d;
      motor_right_drive_o <= motor_r_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A new result only follows a pad-id report in the input stage.
  a_result_from_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_is_pad))
    else $error("result raised without a pad report");

  // Previous-report state moves only when a pad report retires.
  a_prev_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_upd |=> ($stable(prev_hat_face_q) && $stable(prev_trig_l_q)
                    && $stable(prev_sys_q)))
    else $error("previous report changed without a retiring pad report");

  // An unchanged report must leave the held pad state alone.
  a_held_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_upd && !changed) |=> ($stable(held_buttons_q) && $stable(held_trig_r_q)))
    else $error("held state rebuilt on an unchanged report");

  // Foreign report ids never stall the input side.
  a_drop_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_is_pad) |-> !in_stall_o)
    else $error("dropped report stalled the input");

endmodule
